// ===== design/riff_wave_locator_defines.svh =====
// ----------------------------------------------------------------------------
// RIFF wave locator assertion macros
// Shared property wrappers for the locator's checks.
// ----------------------------------------------------------------------------
`ifndef RIFF_WAVE_LOCATOR_DEFINES_SVH
`define RIFF_WAVE_LOCATOR_DEFINES_SVH

// check on every clock edge outside reset
`define RIFF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define RIFF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/riff_pkg.sv =====
// ----------------------------------------------------------------------------
// riff_pkg
// Types, codes and constants shared by the RIFF wave locator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package riff_pkg;

   localparam int POS_BITS       = 32;
   localparam int WEND_BITS      = ((POS_BITS > 32) ? POS_BITS : 32) + 1;
   localparam int SKIP_BITS      = 33;
   localparam int HDR_BITS       = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
   localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
   localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_WALK   = 2'd1,
      PH_DONE   = 2'd2
   } riff_phase_type;

   typedef enum logic [2:0] {
      EV_FOUND     = 3'd0,
      EV_CHUNK     = 3'd1,
      EV_END       = 3'd2,
      EV_NOT_FOUND = 3'd3,
      EV_TRUNCATED = 3'd4
   } riff_event_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET = 1'd0,
      CSR_PAD    = 1'd1
   } riff_csr_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } riff_req_type;

   typedef struct packed {
      riff_event_type event_kind;
      logic [31:0]    byte_offset;
      logic [31:0]    chunk_tag;
      logic [31:0]    length_value;
      logic           is_target;
      logic           last_of_run;
   } riff_rsp_type;

   // results of one byte: a found/chunk report, then an end/eof report
   typedef struct packed {
      logic           main_valid;
      riff_event_type main_kind;
      logic [31:0]    main_offset;
      logic [31:0]    main_tag;
      logic [31:0]    main_length;
      logic           main_target;
      logic           tail_valid;
      riff_event_type tail_kind;
      logic [31:0]    tail_offset;
   } riff_rec_type;

   typedef struct packed {
      logic         push;
      riff_rec_type rec;
   } riff_push_type;

endpackage

`default_nettype wire

// ===== design/riff_front.sv =====
// ----------------------------------------------------------------------------
// riff_front
// Byte parser: signature search, chunk header walk and event classification.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire riff_pkg::riff_req_type req_data,
   input  wire logic                   csr_write,
   input  wire logic [riff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]            csr_data,
   output riff_pkg::riff_push_type     push_out
);
   import riff_pkg::*;

   riff_phase_type          phase_ff, phase_in;
   logic [POS_BITS-1:0]     position_ff, position_in;
   logic [11:0][7:0]        window_ff, window_in;
   logic [WEND_BITS-1:0]    wave_end_ff, wave_end_in;
   logic [HDR_BITS-1:0]     hdr_count_ff, hdr_count_in;
   logic [POS_BITS-1:0]     hdr_start_ff, hdr_start_in;
   logic [31:0]             tag_ff, tag_in;
   logic [31:0]             size_ff, size_in;
   logic [SKIP_BITS-1:0]    skip_ff, skip_in;
   logic [31:0]             target_ff;
   logic                    pad_ff;

   logic [POS_BITS:0]       next_pos;
   logic [POS_BITS-1:0]     wave_start;
   logic [31:0]             riff_len;
   riff_rec_type            rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= FMT_TAG;
         pad_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET: target_ff <= csr_data;
            CSR_PAD:    pad_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         position_ff  <= '0;
         window_ff    <= '0;
         wave_end_ff  <= '0;
         hdr_count_ff <= '0;
         skip_ff      <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         window_ff    <= window_in;
         wave_end_ff  <= wave_end_in;
         hdr_count_ff <= hdr_count_in;
         skip_ff      <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_start_ff <= hdr_start_in;
         tag_ff       <= tag_in;
         size_ff      <= size_in;
      end
   end

   always_comb begin
      next_pos     = {1'b0, position_ff} + (POS_BITS+1)'(1);
      wave_start   = position_ff - POS_BITS'(11);
      phase_in     = phase_ff;
      window_in    = window_ff;
      wave_end_in  = wave_end_ff;
      hdr_count_in = hdr_count_ff;
      hdr_start_in = hdr_start_ff;
      tag_in       = tag_ff;
      size_in      = size_ff;
      skip_in      = skip_ff;
      riff_len     = '0;
      rec          = '0;
      rec.main_kind = EV_FOUND;
      rec.tail_kind = EV_END;

      unique case (phase_ff)
         PH_SEARCH: begin
            window_in = {req_data.data_byte, window_ff[11:1]};
            riff_len  = {window_in[7], window_in[6], window_in[5], window_in[4]};
            if ({window_in[3], window_in[2], window_in[1], window_in[0]} == RIFF_TAG &&
                {window_in[11], window_in[10], window_in[9], window_in[8]} == WAVE_TAG)
            begin
               wave_end_in     = WEND_BITS'(wave_start) + WEND_BITS'(8) +
                                 WEND_BITS'(riff_len);
               hdr_count_in    = '0;
               skip_in         = '0;
               phase_in        = PH_WALK;
               rec.main_valid  = 1'b1;
               rec.main_kind   = EV_FOUND;
               rec.main_offset = 32'(wave_start);
               rec.main_length = riff_len;
            end
         end
         PH_WALK: begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - SKIP_BITS'(1);
            end else begin
               if (hdr_count_ff == '0) begin
                  hdr_start_in = position_ff;
               end
               if (!hdr_count_ff[2]) begin
                  tag_in[{hdr_count_ff[1:0], 3'b000} +: 8] = req_data.data_byte;
               end else begin
                  size_in[{hdr_count_ff[1:0], 3'b000} +: 8] = req_data.data_byte;
               end
               if (hdr_count_ff == HDR_BITS'(7)) begin
                  hdr_count_in    = '0;
                  skip_in         = SKIP_BITS'(size_in) + SKIP_BITS'(pad_ff & size_in[0]);
                  rec.main_valid  = 1'b1;
                  rec.main_kind   = EV_CHUNK;
                  rec.main_offset = 32'(hdr_start_in);
                  rec.main_tag    = tag_in;
                  rec.main_length = size_in;
                  rec.main_target = (tag_in == target_ff);
               end else begin
                  hdr_count_in = hdr_count_ff + HDR_BITS'(1);
               end
            end
         end
         default: ;
      endcase

      // header boundary at or past the wave end: close the walk
      if (phase_in == PH_WALK && hdr_count_in == '0 && skip_in == '0 &&
          WEND_BITS'(next_pos) >= wave_end_in) begin
         rec.tail_valid  = 1'b1;
         rec.tail_kind   = EV_END;
         rec.tail_offset = 32'(wave_end_in);
         phase_in        = PH_DONE;
      end

      position_in = next_pos[POS_BITS-1:0];

      if (req_data.end_of_file) begin
         if (phase_in == PH_SEARCH) begin
            rec.tail_valid  = 1'b1;
            rec.tail_kind   = EV_NOT_FOUND;
            rec.tail_offset = 32'(next_pos);
         end else if (phase_in == PH_WALK) begin
            rec.tail_valid  = 1'b1;
            rec.tail_kind   = EV_TRUNCATED;
            rec.tail_offset = 32'(next_pos);
         end
         phase_in     = PH_SEARCH;
         position_in  = '0;
         window_in    = '0;
         wave_end_in  = '0;
         hdr_count_in = '0;
         skip_in      = '0;
      end

      push_out.push = accept & (rec.main_valid | rec.tail_valid);
      push_out.rec  = rec;
   end

endmodule

`default_nettype wire

// ===== design/riff_queue.sv =====
// ----------------------------------------------------------------------------
// riff_queue
// Short record queue between the parser and the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "riff_wave_locator_defines.svh"

module riff_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire riff_pkg::riff_push_type push_in,
   input  wire logic                    pop,
   output riff_pkg::riff_rec_type       head,
   output logic                         empty,
   output logic                         full
);
   import riff_pkg::*;

   riff_rec_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push_in.push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (!push_in.push && pop) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.rec;
      end
   end

   `RIFF_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH)), "queue count past depth")
   `RIFF_ASSERT(a_pop_nonempty, clock, reset, pop |-> !empty, "pop from empty queue")
   `RIFF_ASSERT(a_push_room, clock, reset, push_in.push |-> (!full || pop), "push into full queue")
   `RIFF_ASSERT(a_push_count, clock, reset, (push_in.push && !pop) |=> (count_ff == $past(count_ff) + QUEUE_CNT_BITS'(1)), "push lost")

endmodule

`default_nettype wire

// ===== design/riff_back.sv =====
// ----------------------------------------------------------------------------
// riff_back
// Result serializer: unpacks queued records into single result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "riff_wave_locator_defines.svh"

module riff_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire riff_pkg::riff_rec_type head,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   input  wire logic                   rsp_pop,
   output logic                        rsp_empty,
   output riff_pkg::riff_rsp_type      rsp_data
);
   import riff_pkg::*;

   logic         out_valid_ff, out_valid_in;
   riff_rsp_type out_ff, out_in;
   logic         tail_next_ff, tail_next_in;
   logic         load;
   logic         take_main;
   logic         rec_done;

   always_comb begin
      load         = !q_empty && (!out_valid_ff || rsp_pop);
      take_main    = !tail_next_ff && head.main_valid;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      tail_next_in = tail_next_ff;
      if (take_main) begin
         rec_done = !head.tail_valid;
      end else begin
         rec_done = 1'b1;
      end
      if (load) begin
         out_valid_in = 1'b1;
         tail_next_in = !rec_done;
         if (take_main) begin
            out_in.event_kind   = head.main_kind;
            out_in.byte_offset  = head.main_offset;
            out_in.chunk_tag    = head.main_tag;
            out_in.length_value = head.main_length;
            out_in.is_target    = head.main_target;
            out_in.last_of_run  = !head.tail_valid;
         end else begin
            out_in.event_kind   = head.tail_kind;
            out_in.byte_offset  = head.tail_offset;
            out_in.chunk_tag    = '0;
            out_in.length_value = '0;
            out_in.is_target    = 1'b0;
            out_in.last_of_run  = 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      q_pop     = load && rec_done;
      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         tail_next_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         tail_next_ff <= tail_next_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   `RIFF_ASSERT(a_tail_has_head, clock, reset, tail_next_ff |-> !q_empty, "tail pending without record")
   `RIFF_ASSERT(a_tail_last, clock, reset, (out_valid_ff && tail_next_ff) |-> !out_ff.last_of_run, "last flag before tail")

endmodule

`default_nettype wire

// ===== design/riff_wave_locator.sv =====
// ----------------------------------------------------------------------------
// riff_wave_locator
// Finds a RIFF/WAVE signature in a byte stream and reports its chunk headers.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle on the request queue port while the record
// queue has room. The parser handles a byte in the cycle it is accepted and
// files its results (at most two: a found or chunk report, then a wave end,
// not found or truncated report) as one record in a four-record queue. The
// serializer delivers one result transaction per cycle from its output register
// while the receiver pops, so a byte with two results gives two transactions;
// req_full rises only while the record queue is full. Configuration writes are
// always ready and take effect on the next accepted byte.
`default_nettype none

module riff_wave_locator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire riff_pkg::riff_req_type req_data,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output riff_pkg::riff_rsp_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [riff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);
   import riff_pkg::*;

   riff_push_type front_push;
   riff_rec_type  q_head;
   logic          q_empty;
   logic          q_full;
   logic          q_pop;
   logic          accept;

   assign accept    = req_push & ~q_full;
   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   riff_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push_out  (front_push)
   );

   riff_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (front_push),
      .pop     (q_pop),
      .head    (q_head),
      .empty   (q_empty),
      .full    (q_full)
   );

   riff_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_locator testbench
// Streams short files into the locator, some hand-built and most generated as
// RIFF/WAVE images with random chunks, noise, bad lengths and early ends. A
// scan tracker in the bench predicts every report, and each popped result is
// compared field by field. Both queue ports idle at random, and one long
// receiver stall backs the block up until it refuses bytes.
// ----------------------------------------------------------------------------

module tb;
   import riff_pkg::*;

   localparam logic [31:0] DATA_TAG    = 32'h6174_6164;
   localparam logic [31:0] FACT_TAG    = 32'h7463_6166;
   localparam int          HOLD_CYCLES = 200;
   localparam int          CYCLE_LIMIT = 400000;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_push  = 1'b0;
   logic                      req_full;
   riff_req_type              req_data  = '0;
   logic                      rsp_empty;
   logic                      rsp_pop   = 1'b0;
   riff_rsp_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0]               csr_data  = '0;

   // scan tracker state
   logic [31:0]    scan_target;
   logic           scan_pad;
   logic [31:0]    scan_pos;
   logic [7:0]     scan_win[12];
   riff_phase_type scan_phase;
   logic [31:0]    scan_wstart;
   logic [63:0]    scan_wend;
   logic [3:0]     scan_hcount;
   logic [31:0]    scan_hstart;
   logic [31:0]    scan_tag;
   logic [31:0]    scan_size;
   logic [32:0]    scan_skip;

   riff_rsp_type step_events[$];
   riff_rsp_type pending_events[$];
   logic [7:0]   file_bytes[$];

   int error_count      = 0;
   int bytes_sent       = 0;
   int cycle_count      = 0;
   bit sender_gapless   = 1'b0;
   bit receiver_gapless = 1'b0;
   bit hold_request     = 1'b0;
   int hold_left        = 0;
   int pop_idle         = 0;

   riff_wave_locator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------- tracker
   function automatic void clear_scan();
      scan_pos    = '0;
      foreach (scan_win[i]) scan_win[i] = '0;
      scan_phase  = PH_SEARCH;
      scan_wstart = '0;
      scan_wend   = '0;
      scan_hcount = '0;
      scan_hstart = '0;
      scan_tag    = '0;
      scan_size   = '0;
      scan_skip   = '0;
   endfunction

   function automatic void note_event(riff_event_type kind, logic [31:0] offset,
                                      logic [31:0] tag, logic [31:0] length, logic hit);
      riff_rsp_type ev;
      ev.event_kind   = kind;
      ev.byte_offset  = offset;
      ev.chunk_tag    = tag;
      ev.length_value = length;
      ev.is_target    = hit;
      ev.last_of_run  = 1'b0;
      step_events.push_back(ev);
   endfunction

   function automatic void close_if_past_end(logic [32:0] nxt);
      if (scan_phase == PH_WALK && scan_hcount == 0 && scan_skip == 0 &&
          nxt >= scan_wend) begin
         note_event(EV_END, scan_wend[31:0], '0, '0, 1'b0);
         scan_phase = PH_DONE;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] value, logic last);
      logic [32:0]  nxt;
      logic [31:0]  len;
      int           k;
      riff_rsp_type ev;
      step_events.delete();
      nxt = {1'b0, scan_pos} + 33'd1;
      if (scan_phase == PH_SEARCH) begin
         for (int i = 0; i < 11; i++) scan_win[i] = scan_win[i + 1];
         scan_win[11] = value;
         if ({scan_win[3], scan_win[2], scan_win[1], scan_win[0]} == RIFF_TAG &&
             {scan_win[11], scan_win[10], scan_win[9], scan_win[8]} == WAVE_TAG) begin
            len         = {scan_win[7], scan_win[6], scan_win[5], scan_win[4]};
            scan_wstart = scan_pos - 32'd11;
            scan_wend   = {32'd0, scan_wstart} + 64'd8 + {32'd0, len};
            scan_hcount = '0;
            scan_skip   = '0;
            scan_phase  = PH_WALK;
            note_event(EV_FOUND, scan_wstart, '0, len, 1'b0);
            close_if_past_end(nxt);
         end
      end else if (scan_phase == PH_WALK) begin
         if (scan_skip != 0) begin
            scan_skip = scan_skip - 33'd1;
         end else begin
            k = scan_hcount[2:0];
            if (k == 0) scan_hstart = scan_pos;
            if (k < 4) scan_tag[8*k +: 8] = value;
            else scan_size[8*(k-4) +: 8] = value;
            if (k == 7) begin
               scan_hcount = '0;
               scan_skip   = {1'b0, scan_size} + (scan_pad & scan_size[0]);
               note_event(EV_CHUNK, scan_hstart, scan_tag, scan_size,
                          scan_tag == scan_target);
            end else begin
               scan_hcount = k + 1;
            end
         end
         close_if_past_end(nxt);
      end
      scan_pos = nxt[31:0];
      if (last) begin
         if (scan_phase == PH_SEARCH) note_event(EV_NOT_FOUND, nxt[31:0], '0, '0, 1'b0);
         else if (scan_phase == PH_WALK) note_event(EV_TRUNCATED, nxt[31:0], '0, '0, 1'b0);
         clear_scan();
      end
      foreach (step_events[i]) begin
         ev = step_events[i];
         ev.last_of_run = (i == step_events.size() - 1);
         pending_events.push_back(ev);
      end
   endfunction

   // ---------------------------------------------------------------- checker
   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      riff_rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", want.event_kind, rsp_data.event_kind);
            check_field("byte_offset", want.byte_offset, rsp_data.byte_offset);
            check_field("chunk_tag", want.chunk_tag, rsp_data.chunk_tag);
            check_field("length_value", want.length_value, rsp_data.length_value);
            check_field("is_target", want.is_target, rsp_data.is_target);
            check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   // receiver: random pops, gapless stretches, and a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_pop <= 1'b0;
      end else if (receiver_gapless) begin
         rsp_pop <= 1'b1;
      end else if (pop_idle != 0) begin
         pop_idle--;
         rsp_pop <= 1'b0;
      end else begin
         pop_idle = idle_gap();
         if (pop_idle == 0) begin
            rsp_pop <= 1'b1;
         end else begin
            pop_idle--;
            rsp_pop <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_byte(input logic [7:0] value, input logic last);
      int           gap;
      riff_req_type item;
      gap = sender_gapless ? 0 : idle_gap();
      item.data_byte   = value;
      item.end_of_file = last;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      parse_byte(value, last);
      bytes_sent++;
   endtask

   task automatic send_file();
      int count;
      count = file_bytes.size();
      for (int i = 0; i < count; i++) send_byte(file_bytes[i], i == count - 1);
   endtask

   task automatic wait_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   task automatic csr_write(input riff_csr_type idx, input logic [31:0] value);
      wait_drain();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TARGET) scan_target = value;
      else scan_pad = value[0];
   endtask

   task automatic set_config(input logic [31:0] target, input logic pad);
      csr_write(CSR_TARGET, target);
      csr_write(CSR_PAD, {31'd0, pad});
   endtask

   // ---------------------------------------------------------------- file images
   function automatic void add_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic logic [31:0] pick_chunk_id();
      case ($urandom_range(0, 5))
         0: return scan_target;
         1: return FMT_TAG;
         2: return DATA_TAG;
         3: return FACT_TAG;
         4: return scan_target ^ (32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic void build_wave_file(int n_chunks, int max_size, bit clean);
      int          len_at;
      int          cut;
      bit          cut_short;
      logic [31:0] size;
      logic [31:0] riff_len;
      file_bytes.delete();
      cut_short = 1'b0;
      if (!clean) begin
         case ($urandom_range(0, 3))
            1: repeat ($urandom_range(1, 5)) file_bytes.push_back($urandom_range(0, 255));
            2: begin
               add_word(RIFF_TAG);
               add_word($urandom);
               add_word(WAVE_TAG ^ (32'd1 << $urandom_range(0, 31)));
            end
            default: ;
         endcase
      end
      add_word(RIFF_TAG);
      len_at = file_bytes.size();
      add_word(32'd0);
      add_word(WAVE_TAG);
      for (int c = 0; c < n_chunks && !cut_short; c++) begin
         if (!clean && $urandom_range(0, 9) == 0) size = $urandom;
         else size = $urandom_range(0, max_size);
         add_word(pick_chunk_id());
         add_word(size);
         if (size > 64) begin
            // body far past the file end: stop the image early
            repeat ($urandom_range(0, 6)) file_bytes.push_back($urandom_range(0, 255));
            cut_short = 1'b1;
         end else begin
            repeat (size) file_bytes.push_back($urandom_range(0, 255));
            if (size[0] && (clean ? scan_pad : (scan_pad ^ ($urandom_range(0, 5) == 0))))
               file_bytes.push_back($urandom_range(0, 255));
         end
      end
      riff_len = file_bytes.size() - (len_at + 4);
      if (!clean) begin
         case ($urandom_range(0, 9))
            7: riff_len = $urandom_range(0, 12);
            8: riff_len = riff_len + $urandom_range(0, 8) - 4;
            9: riff_len = $urandom;
            default: ;
         endcase
         repeat ($urandom_range(0, 3)) file_bytes.push_back($urandom_range(0, 255));
         if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
         end
      end
      for (int i = 0; i < 4; i++)
         if (len_at + i < file_bytes.size()) file_bytes[len_at + i] = riff_len[8*i +: 8];
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_not_found();
      file_bytes = '{8'h52};
      send_file();
   endtask

   task automatic test_short_length();
      file_bytes.delete();
      add_word(RIFF_TAG);
      add_word(32'd0);
      add_word(WAVE_TAG);
      send_file();
   endtask

   task automatic test_truncated_header();
      file_bytes.delete();
      add_word(RIFF_TAG);
      add_word(32'hFFFF_FFFF);
      add_word(WAVE_TAG);
      add_word(FMT_TAG);
      add_word(32'd1);
      send_file();
   endtask

   task automatic test_register_sweep();
      logic [31:0] targets[4];
      targets = '{32'd0, 32'hFFFF_FFFF, DATA_TAG, FACT_TAG};
      for (int s = 0; s < 4; s++) begin
         set_config(targets[s], (s % 2) == 0);
         sender_gapless   = (s == 2);
         receiver_gapless = (s == 2);
         build_wave_file($urandom_range(1, 3), 5, 1'b0);
         send_file();
      end
      sender_gapless   = 1'b0;
      receiver_gapless = 1'b0;
   endtask

   task automatic test_backpressure();
      set_config(DATA_TAG, 1'b1);
      hold_request   = 1'b1;
      sender_gapless = 1'b1;
      build_wave_file(9, 0, 1'b1);
      send_file();
      sender_gapless = 1'b0;
      wait_drain();
   endtask

   task automatic test_random_stream();
      while (bytes_sent < 380) begin
         sender_gapless   = ($urandom_range(0, 5) == 0);
         receiver_gapless = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 11))
            0: set_config($urandom_range(0, 1) ? $urandom : pick_chunk_id(),
                          $urandom_range(0, 1));
            1: wait_drain();
            2, 3: begin
               file_bytes.delete();
               repeat ($urandom_range(1, 12)) file_bytes.push_back($urandom_range(0, 255));
               send_file();
            end
            4: begin
               build_wave_file($urandom_range(1, 3), 40, 1'b0);
               send_file();
            end
            default: begin
               build_wave_file($urandom_range(0, 4), 6, 1'b0);
               send_file();
            end
         endcase
      end
      sender_gapless   = 1'b0;
      receiver_gapless = 1'b0;
   endtask

   initial begin
      scan_target = FMT_TAG;
      scan_pad    = 1'b0;
      clear_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_not_found();
      test_short_length();
      test_truncated_header();
      test_register_sweep();
      test_backpressure();
      test_random_stream();
      wait_drain();
      repeat (16) @(posedge clock);
      if (error_count == 0 && pending_events.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/riff_pkg.sv
design/riff_front.sv
design/riff_queue.sv
design/riff_back.sv
design/riff_wave_locator.sv
test/tb.sv
